// ===== design/tlast_pkg.sv =====
// Shared types, widths and constants of the two-link arm step targeter.
// No dependencies; every design file refers to this package by scoped names.
package tlast_pkg;

    localparam int COORD_WIDTH       = 13;
    localparam int CORDIC_ITERATIONS = 16;

    localparam int L_W    = 12;
    localparam int OFS_W  = 13;
    localparam int SPD_W  = 16;
    localparam int STEP_W = 14;
    localparam int MOVE_W = 15;

    // Working widths of the solver.
    localparam int XY_W   = ((COORD_WIDTH > OFS_W) ? COORD_WIDTH : OFS_W) + 1;
    localparam int R2_W   = 2 * XY_W;
    localparam int T_W    = R2_W + 1;
    localparam int B_W    = 26;
    localparam int TT_W   = B_W + 1;
    localparam int S_W    = 26;
    localparam int RAD_W  = 2 * S_W;
    localparam int MUL_W  = 30;
    localparam int PROD_W = 2 * MUL_W;
    localparam int K_W    = 41;
    localparam int CD_W   = 44;
    localparam int Z_W    = 27;
    localparam int ANG_W  = 28;
    localparam int IT_W   = 5;
    localparam int STEP_SHIFT = 24;

    localparam logic signed [Z_W-1:0] DEG180 = Z_W'(180 * 65536);

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_L1    = 3'd0,
        REG_L2    = 3'd1,
        REG_OFS_X = 3'd2,
        REG_OFS_Y = 3'd3,
        REG_SPD   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [L_W-1:0]          l1;
        logic [L_W-1:0]          l2;
        logic signed [OFS_W-1:0] ofs_x;
        logic signed [OFS_W-1:0] ofs_y;
        logic [SPD_W-1:0]        spd;
    } t_cfg;

    // atan(2^-i) in degrees, Q16, rounded.
    function automatic logic signed [Z_W-1:0] atan_tab(input logic [IT_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:    v = Z_W'(2949120);
            5'd1:    v = Z_W'(1740967);
            5'd2:    v = Z_W'(919879);
            5'd3:    v = Z_W'(466945);
            5'd4:    v = Z_W'(234379);
            5'd5:    v = Z_W'(117304);
            5'd6:    v = Z_W'(58666);
            5'd7:    v = Z_W'(29335);
            5'd8:    v = Z_W'(14668);
            5'd9:    v = Z_W'(7334);
            5'd10:   v = Z_W'(3667);
            5'd11:   v = Z_W'(1833);
            5'd12:   v = Z_W'(917);
            5'd13:   v = Z_W'(458);
            5'd14:   v = Z_W'(229);
            5'd15:   v = Z_W'(115);
            5'd16:   v = Z_W'(57);
            5'd17:   v = Z_W'(29);
            5'd18:   v = Z_W'(14);
            5'd19:   v = Z_W'(7);
            5'd20:   v = Z_W'(4);
            5'd21:   v = Z_W'(2);
            5'd22:   v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/tlast_cfg.sv =====
// APB-style register bank holding the arm geometry, origin offset and step scale.
// Depends on tlast_pkg.
module tlast_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tlast_pkg::ADDR_W-1:0]  paddr,
    input  logic [tlast_pkg::DATA_W-1:0]  pwdata,
    output logic [tlast_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output tlast_pkg::t_cfg               o_cfg
);

    tlast_pkg::t_cfg    r_cfg;
    tlast_pkg::t_reg_idx idx;

    assign idx    = tlast_pkg::t_reg_idx'(paddr[tlast_pkg::ADDR_W-1:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.l1    <= tlast_pkg::L_W'(150);
            r_cfg.l2    <= tlast_pkg::L_W'(150);
            r_cfg.ofs_x <= '0;
            r_cfg.ofs_y <= '0;
            r_cfg.spd   <= tlast_pkg::SPD_W'(2276);
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                tlast_pkg::REG_L1:    r_cfg.l1    <= pwdata[tlast_pkg::L_W-1:0];
                tlast_pkg::REG_L2:    r_cfg.l2    <= pwdata[tlast_pkg::L_W-1:0];
                tlast_pkg::REG_OFS_X: r_cfg.ofs_x <= pwdata[tlast_pkg::OFS_W-1:0];
                tlast_pkg::REG_OFS_Y: r_cfg.ofs_y <= pwdata[tlast_pkg::OFS_W-1:0];
                tlast_pkg::REG_SPD:   r_cfg.spd   <= pwdata[tlast_pkg::SPD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            tlast_pkg::REG_L1:    prdata = tlast_pkg::DATA_W'(r_cfg.l1);
            tlast_pkg::REG_L2:    prdata = tlast_pkg::DATA_W'(r_cfg.l2);
            tlast_pkg::REG_OFS_X: prdata = tlast_pkg::DATA_W'(unsigned'(r_cfg.ofs_x));
            tlast_pkg::REG_OFS_Y: prdata = tlast_pkg::DATA_W'(unsigned'(r_cfg.ofs_y));
            tlast_pkg::REG_SPD:   prdata = tlast_pkg::DATA_W'(r_cfg.spd);
            default:              prdata = '0;
        endcase
    end

endmodule

// ===== design/tlast_isqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on tlast_pkg.
module tlast_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tlast_pkg::RAD_W-1:0]  i_rad,
    output logic                         o_busy,
    output logic [tlast_pkg::S_W-1:0]    o_root
);

    localparam int CNT_W = $clog2(tlast_pkg::S_W);

    logic                          r_busy;
    logic [CNT_W-1:0]              r_cnt;
    logic [tlast_pkg::RAD_W-1:0]   r_v;
    logic [tlast_pkg::S_W:0]       r_rem;
    logic [tlast_pkg::S_W-1:0]     r_res;
    logic [tlast_pkg::S_W+2:0]     rem2;
    logic [tlast_pkg::S_W+2:0]     trial;

    assign rem2   = {r_rem, r_v[tlast_pkg::RAD_W-1 -: 2]};
    assign trial  = {1'b0, r_res, 2'b01};
    assign o_busy = r_busy;
    assign o_root = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_v    <= i_rad;
            r_rem  <= '0;
            r_res  <= '0;
        end else if (r_busy) begin
            r_v <= {r_v[tlast_pkg::RAD_W-3:0], 2'b00};
            if (rem2 >= trial) begin
                r_rem <= (tlast_pkg::S_W+1)'(rem2 - trial);
                r_res <= {r_res[tlast_pkg::S_W-2:0], 1'b1};
            end else begin
                r_rem <= rem2[tlast_pkg::S_W:0];
                r_res <= {r_res[tlast_pkg::S_W-2:0], 1'b0};
            end
            if (r_cnt == CNT_W'(tlast_pkg::S_W - 1)) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

endmodule

// ===== design/tlast_cordic.sv =====
// Vectoring CORDIC atan2 in Q16 degrees with a one-or-four-bit-per-cycle normalizer.
// Depends on tlast_pkg for widths and the arctangent table.
module tlast_cordic (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [tlast_pkg::CD_W-1:0]  i_y,
    input  logic signed [tlast_pkg::CD_W-1:0]  i_x,
    output logic                               o_busy,
    output logic signed [tlast_pkg::Z_W-1:0]   o_z
);

    typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} t_cstate;

    t_cstate                            r_state;
    logic signed [tlast_pkg::CD_W-1:0]  r_x;
    logic signed [tlast_pkg::CD_W-1:0]  r_y;
    logic signed [tlast_pkg::Z_W-1:0]   r_z;
    logic [tlast_pkg::IT_W-1:0]         r_i;
    logic [tlast_pkg::CD_W-1:0]         ay;
    logic [tlast_pkg::CD_W-1:0]         m;
    logic signed [tlast_pkg::CD_W-1:0]  dx;
    logic signed [tlast_pkg::CD_W-1:0]  dy;

    // Arithmetic shift right that truncates toward zero.
    function automatic logic signed [tlast_pkg::CD_W-1:0] tz_shr(
        input logic signed [tlast_pkg::CD_W-1:0] v,
        input logic [tlast_pkg::IT_W-1:0]        k
    );
        logic signed [tlast_pkg::CD_W-1:0] r;
        if (v[tlast_pkg::CD_W-1]) begin
            r = -((-v) >>> k);
        end else begin
            r = v >>> k;
        end
        return r;
    endfunction

    always_comb begin
        ay = r_y[tlast_pkg::CD_W-1] ? unsigned'(-r_y) : unsigned'(r_y);
        m  = (unsigned'(r_x) > ay) ? unsigned'(r_x) : ay;
        dx = tz_shr(r_y, r_i);
        dy = tz_shr(r_x, r_i);
    end

    assign o_busy = (r_state != C_IDLE);
    assign o_z    = r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_i     <= '0;
        end else begin
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_i <= '0;
                        if (i_x == '0 && i_y == '0) begin
                            r_z <= '0;
                        end else begin
                            r_state <= C_NORM;
                            if (i_x[tlast_pkg::CD_W-1]) begin
                                r_x <= -i_x;
                                r_y <= -i_y;
                                r_z <= i_y[tlast_pkg::CD_W-1] ? -tlast_pkg::DEG180
                                                              : tlast_pkg::DEG180;
                            end else begin
                                r_x <= i_x;
                                r_y <= i_y;
                                r_z <= '0;
                            end
                        end
                    end
                end
                C_NORM: begin
                    // Bring the larger magnitude into [2^30, 2^31).
                    if (m < (tlast_pkg::CD_W'(1) << 26)) begin
                        r_x <= r_x <<< 4;
                        r_y <= r_y <<< 4;
                    end else if (m < (tlast_pkg::CD_W'(1) << 30)) begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end else if (m >= (tlast_pkg::CD_W'(1) << 35)) begin
                        r_x <= tz_shr(r_x, tlast_pkg::IT_W'(4));
                        r_y <= tz_shr(r_y, tlast_pkg::IT_W'(4));
                    end else if (m >= (tlast_pkg::CD_W'(1) << 31)) begin
                        r_x <= tz_shr(r_x, tlast_pkg::IT_W'(1));
                        r_y <= tz_shr(r_y, tlast_pkg::IT_W'(1));
                    end else begin
                        r_state <= C_ITER;
                    end
                end
                C_ITER: begin
                    if (!r_y[tlast_pkg::CD_W-1] && r_y != '0) begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + tlast_pkg::atan_tab(r_i);
                    end else begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - tlast_pkg::atan_tab(r_i);
                    end
                    if (r_i == tlast_pkg::IT_W'(tlast_pkg::CORDIC_ITERATIONS - 1)) begin
                        r_state <= C_IDLE;
                    end
                    r_i <= r_i + 1'b1;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

endmodule

// ===== design/two_link_arm_step_targeter.sv =====
// Two-link arm step targeter: a home command goes straight to the done state, an
// unreachable point stops after the reach test, and a move runs one square root
// and three CORDIC runs, one after another.
// One item is taken at a time; the input stalls until its result is registered.
// Reset is synchronous: both positions go to zero and the registers to defaults.
module two_link_arm_step_targeter (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_in_valid,
    output logic                                        o_in_stall,
    input  logic                                        i_cmd,
    input  logic signed [tlast_pkg::COORD_WIDTH-1:0]    i_target_x,
    input  logic signed [tlast_pkg::COORD_WIDTH-1:0]    i_target_y,
    output logic                                        o_out_valid,
    input  logic                                        i_out_stall,
    output logic signed [tlast_pkg::STEP_W-1:0]         o_shoulder_target_steps,
    output logic signed [tlast_pkg::STEP_W-1:0]         o_elbow_target_steps,
    output logic signed [tlast_pkg::MOVE_W-1:0]         o_shoulder_move_steps,
    output logic signed [tlast_pkg::MOVE_W-1:0]         o_elbow_move_steps,
    output logic                                        o_unreachable,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [tlast_pkg::ADDR_W-1:0]                paddr,
    input  logic [tlast_pkg::DATA_W-1:0]                pwdata,
    output logic [tlast_pkg::DATA_W-1:0]                prdata,
    output logic                                        pready
);

    // The sequencer walks the solution one step per state. A single registered
    // multiplier serves every product: a state that needs one issues it, and the
    // state after it uses the result.
    typedef enum logic [4:0] {
        S_IDLE, S_XX, S_YY, S_L1, S_L2, S_B, S_CHK, S_TEST, S_TT, S_RAD,
        S_SQ0, S_SQW, S_M1, S_M2, S_M3, S_M4, S_AT1, S_AT2S, S_AT2,
        S_AT3S, S_AT3, S_CVE, S_CVS, S_CVD, S_DONE
    } t_state;

    tlast_pkg::t_cfg cfg;

    t_state                                   r_state;
    logic signed [tlast_pkg::XY_W-1:0]        r_x;
    logic signed [tlast_pkg::XY_W-1:0]        r_y;
    logic [tlast_pkg::R2_W-1:0]               r_r2;
    logic signed [tlast_pkg::T_W-1:0]         r_t;
    logic [tlast_pkg::B_W-1:0]                r_b;
    logic [tlast_pkg::RAD_W-1:0]              r_rad;
    logic [tlast_pkg::S_W-1:0]                r_s;
    logic signed [tlast_pkg::K_W-1:0]         r_cy;
    logic signed [tlast_pkg::K_W-1:0]         r_k;
    logic signed [tlast_pkg::ANG_W-1:0]       r_el;
    logic signed [tlast_pkg::ANG_W-1:0]       r_sh;
    logic signed [tlast_pkg::STEP_W-1:0]      r_st;
    logic signed [tlast_pkg::STEP_W-1:0]      r_et;
    logic                                     r_unr;
    logic signed [tlast_pkg::STEP_W-1:0]      r_pos_s;
    logic signed [tlast_pkg::STEP_W-1:0]      r_pos_e;
    logic signed [tlast_pkg::PROD_W-1:0]      r_prod;
    logic                                     r_out_valid;
    logic signed [tlast_pkg::STEP_W-1:0]      r_o_st;
    logic signed [tlast_pkg::STEP_W-1:0]      r_o_et;
    logic signed [tlast_pkg::MOVE_W-1:0]      r_o_sm;
    logic signed [tlast_pkg::MOVE_W-1:0]      r_o_em;
    logic                                     r_o_unr;

    logic signed [tlast_pkg::MUL_W-1:0]       mul_a;
    logic signed [tlast_pkg::MUL_W-1:0]       mul_b;
    logic [tlast_pkg::T_W-1:0]                tmag;
    logic signed [tlast_pkg::K_W-1:0]         kmag;
    logic signed [tlast_pkg::ANG_W-1:0]       el_mag;
    logic signed [tlast_pkg::ANG_W-1:0]       sh_mag;
    logic                                     sq_start;
    logic                                     sq_busy;
    logic [tlast_pkg::S_W-1:0]                sq_root;
    logic                                     cd_start;
    logic                                     cd_busy;
    logic signed [tlast_pkg::CD_W-1:0]        cd_y;
    logic signed [tlast_pkg::CD_W-1:0]        cd_x;
    logic signed [tlast_pkg::Z_W-1:0]         cd_z;

    // Steps from |angle| * steps_per_degree, truncated toward zero, then
    // saturated to the 14-bit step range with the angle's sign.
    function automatic logic signed [tlast_pkg::STEP_W-1:0] to_steps(
        input logic signed [tlast_pkg::PROD_W-1:0] p,
        input logic                                neg
    );
        logic [tlast_pkg::PROD_W-tlast_pkg::STEP_SHIFT-2:0] q;
        logic signed [tlast_pkg::STEP_W-1:0]                 r;
        q = p[tlast_pkg::PROD_W-2:tlast_pkg::STEP_SHIFT];
        if (neg) begin
            r = (q > 8192) ? tlast_pkg::STEP_W'(-8192) : -tlast_pkg::STEP_W'(q);
        end else begin
            r = (q > 8191) ? tlast_pkg::STEP_W'(8191) : tlast_pkg::STEP_W'(q);
        end
        return r;
    endfunction

    tlast_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tlast_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (r_rad),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    tlast_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cd_start),
        .i_y     (cd_y),
        .i_x     (cd_x),
        .o_busy  (cd_busy),
        .o_z     (cd_z)
    );

    always_comb begin
        tmag   = r_t[tlast_pkg::T_W-1] ? unsigned'(-r_t) : unsigned'(r_t);
        kmag   = r_k[tlast_pkg::K_W-1] ? -r_k : r_k;
        el_mag = r_el[tlast_pkg::ANG_W-1] ? -r_el : r_el;
        sh_mag = r_sh[tlast_pkg::ANG_W-1] ? -r_sh : r_sh;
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_XX: begin
                mul_a = tlast_pkg::MUL_W'(r_x);
                mul_b = tlast_pkg::MUL_W'(r_x);
            end
            S_YY: begin
                mul_a = tlast_pkg::MUL_W'(r_y);
                mul_b = tlast_pkg::MUL_W'(r_y);
            end
            S_L1: begin
                mul_a = tlast_pkg::MUL_W'(cfg.l1);
                mul_b = tlast_pkg::MUL_W'(cfg.l1);
            end
            S_L2: begin
                mul_a = tlast_pkg::MUL_W'(cfg.l2);
                mul_b = tlast_pkg::MUL_W'(cfg.l2);
            end
            S_B: begin
                mul_a = tlast_pkg::MUL_W'(cfg.l1);
                mul_b = tlast_pkg::MUL_W'(cfg.l2);
            end
            S_TEST: begin
                mul_a = tlast_pkg::MUL_W'(r_b);
                mul_b = tlast_pkg::MUL_W'(r_b);
            end
            S_TT: begin
                mul_a = tlast_pkg::MUL_W'(tmag[tlast_pkg::B_W-1:0]);
                mul_b = tlast_pkg::MUL_W'(tmag[tlast_pkg::B_W-1:0]);
            end
            S_M1: begin
                mul_a = tlast_pkg::MUL_W'(cfg.l2);
                mul_b = tlast_pkg::MUL_W'(r_s);
            end
            S_M2: begin
                mul_a = tlast_pkg::MUL_W'(cfg.l1);
                mul_b = tlast_pkg::MUL_W'(r_b);
            end
            S_M3: begin
                mul_a = tlast_pkg::MUL_W'(cfg.l2);
                mul_b = tlast_pkg::MUL_W'(signed'(r_t[tlast_pkg::TT_W-1:0]));
            end
            S_CVE: begin
                mul_a = tlast_pkg::MUL_W'(el_mag);
                mul_b = tlast_pkg::MUL_W'(cfg.spd);
            end
            S_CVS: begin
                mul_a = tlast_pkg::MUL_W'(sh_mag);
                mul_b = tlast_pkg::MUL_W'(cfg.spd);
            end
            default: ;
        endcase
    end

    // Operands and start strobes for the square root and CORDIC units.
    always_comb begin
        sq_start = (r_state == S_SQ0);
        cd_start = (r_state == S_M1) || (r_state == S_AT2S) || (r_state == S_AT3S);
        cd_y     = tlast_pkg::CD_W'(r_y);
        cd_x     = tlast_pkg::CD_W'(r_x);
        if (r_state == S_M1) begin
            cd_y = tlast_pkg::CD_W'(r_s);
            cd_x = tlast_pkg::CD_W'(r_t);
        end else if (r_state == S_AT2S) begin
            cd_y = tlast_pkg::CD_W'(r_cy);
            cd_x = tlast_pkg::CD_W'(kmag);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    assign o_in_stall              = (r_state != S_IDLE);
    assign o_out_valid             = r_out_valid;
    assign o_shoulder_target_steps = r_o_st;
    assign o_elbow_target_steps    = r_o_et;
    assign o_shoulder_move_steps   = r_o_sm;
    assign o_elbow_move_steps      = r_o_em;
    assign o_unreachable           = r_o_unr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos_s     <= '0;
            r_pos_e     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A taken beat empties the output register, unless the done state
            // refills it on the same edge.
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_unr <= 1'b0;
                        r_x   <= tlast_pkg::XY_W'(i_target_x) + tlast_pkg::XY_W'(cfg.ofs_x);
                        r_y   <= tlast_pkg::XY_W'(i_target_y) + tlast_pkg::XY_W'(cfg.ofs_y);
                        if (i_cmd) begin
                            // Home: both targets are zero.
                            r_st    <= '0;
                            r_et    <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_XX;
                        end
                    end
                end
                S_XX: r_state <= S_YY;
                S_YY: begin
                    r_r2    <= r_prod[tlast_pkg::R2_W-1:0];
                    r_state <= S_L1;
                end
                S_L1: begin
                    r_r2    <= r_r2 + r_prod[tlast_pkg::R2_W-1:0];
                    r_state <= S_L2;
                end
                S_L2: begin
                    r_t     <= signed'({1'b0, r_r2}) - signed'(r_prod[tlast_pkg::T_W-1:0]);
                    r_state <= S_B;
                end
                S_B: begin
                    r_t     <= r_t - signed'(r_prod[tlast_pkg::T_W-1:0]);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_b     <= {r_prod[tlast_pkg::B_W-2:0], 1'b0};
                    r_state <= S_TEST;
                end
                S_TEST: begin
                    // Out of reach: the point is the origin or the
                    // law-of-cosines term exceeds the full bend.
                    if (r_r2 == '0 || tmag > tlast_pkg::T_W'(r_b)) begin
                        r_unr   <= 1'b1;
                        r_st    <= r_pos_s;
                        r_et    <= r_pos_e;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_TT;
                    end
                end
                S_TT: begin
                    r_rad   <= r_prod[tlast_pkg::RAD_W-1:0];
                    r_state <= S_RAD;
                end
                S_RAD: begin
                    r_rad   <= r_rad - r_prod[tlast_pkg::RAD_W-1:0];
                    r_state <= S_SQ0;
                end
                S_SQ0: r_state <= S_SQW;
                S_SQW: begin
                    if (!sq_busy) begin
                        r_s     <= sq_root;
                        r_state <= S_M1;
                    end
                end
                S_M1: r_state <= S_M2;
                S_M2: begin
                    r_cy    <= r_prod[tlast_pkg::K_W-1:0];
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_k     <= r_prod[tlast_pkg::K_W-1:0];
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_k     <= r_k + signed'(r_prod[tlast_pkg::K_W-1:0]);
                    r_state <= S_AT1;
                end
                S_AT1: begin
                    if (!cd_busy) begin
                        r_el    <= tlast_pkg::ANG_W'(tlast_pkg::DEG180)
                                   - tlast_pkg::ANG_W'(cd_z);
                        r_state <= S_AT2S;
                    end
                end
                S_AT2S: r_state <= S_AT2;
                S_AT2: begin
                    if (!cd_busy) begin
                        r_sh    <= tlast_pkg::ANG_W'(cd_z);
                        r_state <= S_AT3S;
                    end
                end
                S_AT3S: r_state <= S_AT3;
                S_AT3: begin
                    if (!cd_busy) begin
                        r_sh    <= r_sh + tlast_pkg::ANG_W'(cd_z);
                        r_state <= S_CVE;
                    end
                end
                S_CVE: r_state <= S_CVS;
                S_CVS: begin
                    r_et    <= to_steps(r_prod, r_el[tlast_pkg::ANG_W-1]);
                    r_state <= S_CVD;
                end
                S_CVD: begin
                    r_st    <= to_steps(r_prod, r_sh[tlast_pkg::ANG_W-1]);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // Hand the beat to the output register once it is free,
                    // and take the targets as the new positions.
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_st      <= r_st;
                        r_o_et      <= r_et;
                        r_o_sm      <= tlast_pkg::MOVE_W'(r_st) - tlast_pkg::MOVE_W'(r_pos_s);
                        r_o_em      <= tlast_pkg::MOVE_W'(r_et) - tlast_pkg::MOVE_W'(r_pos_e);
                        r_o_unr     <= r_unr;
                        r_pos_s     <= r_st;
                        r_pos_e     <= r_et;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
